/* rtl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types, widths and constants of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Default number of cache entries.
  localparam int unsigned LKVC_ENTRIES = 16;

  // Field widths.
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  // Configuration port geometry: one 32-bit register per 4-byte word.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned REG_IDX_W  = PADDR_W - 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Value returned by a get that misses.
  localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

  // Operation codes.
  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

  // One request as seen by the entry store.
  typedef struct packed {
    func_t                    func;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } lkvc_op_t;

  // Lookup result from the entry store.
  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } lkvc_res_t;

endpackage

/* rtl/lkvc_req_if.sv */
// ----------------------------------------------------------------------------
// lkvc_req_if
// Request channel: operation, key and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lkvc_req_if import lkvc_pkg::*; ();

  logic                     valid;
  logic                     ready;
  func_t                    func;
  logic signed [KEY_W-1:0]  key;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);

endinterface

/* rtl/lkvc_rsp_if.sv */
// ----------------------------------------------------------------------------
// lkvc_rsp_if
// Response channel: hit flag and read value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if import lkvc_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);

endinterface

/* rtl/lru_key_value_cache_core.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | valid/ready        | func, key, value
//  rsp     | out       | valid/ready        | hit, read_value (gets only)
//  apb     | in        | psel/penable/ready | capacity register at 0x0
//
// One transaction is accepted every cycle while no get waits. A request is
// registered, then looked up and applied to the entry store when it advances,
// and a get's response is registered in the response register at that time.
// Reset clears all valid bits and ranks at once; no clearing pass is needed.
// A get waits in the input register while the response register holds an
// untaken response; puts never wait.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = LKVC_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  lkvc_req_if.sink              req,
  lkvc_rsp_if.source            rsp
);

  logic [CAP_W-1:0] capacity;
  logic             s1_valid;
  lkvc_op_t         s1_op;
  logic             s1_is_get;
  logic             advance;
  lkvc_res_t        store_res;
  logic             rsp_valid;
  lkvc_res_t        rsp_res;

  // Configuration registers.
  lkvc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // The registered request proceeds unless it is a get facing a full
  // response register whose response is not being taken.
  assign s1_is_get = (s1_op.func == FUNC_GET);
  assign advance   = s1_valid && (!s1_is_get || !rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op.func  <= req.func;
      s1_op.key   <= req.key;
      s1_op.value <= req.value;
    end
  end

  // Entry store: lookup and state update for the registered request.
  lkvc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .en       (advance),
    .op       (s1_op),
    .res      (store_res)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance && s1_is_get) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_is_get) begin
      rsp_res <= store_res;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_res.hit;
  assign rsp.read_value = rsp_res.read_value;

endmodule

/* rtl/lkvc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lkvc_cfg_regs
// APB-style configuration register file holding the capacity register.
// ----------------------------------------------------------------------------
module lkvc_cfg_regs import lkvc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CAP_W-1:0]      capacity
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  // Word index and write strobe for the access phase.
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_en && (reg_idx == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Read data; unmapped words read as zero.
  always_comb begin
    if (reg_idx == REG_CAPACITY) begin
      prdata = {{(APB_DATA_W - CAP_W){1'b0}}, capacity};
    end else begin
      prdata = '0;
    end
  end

endmodule

/* rtl/lkvc_store.sv */
// ----------------------------------------------------------------------------
// lkvc_store
// Entry store: parallel key match, recency ranks, replacement and update.
// ----------------------------------------------------------------------------
module lkvc_store import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = LKVC_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CAP_W-1:0] capacity,
  input  logic             en,
  input  lkvc_op_t         op,
  output lkvc_res_t        res
);

  localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  // Entry storage. Keys and data need no reset: only valid entries are read.
  logic [KEY_W-1:0]  entry_key  [ENTRIES];
  logic [DATA_W-1:0] entry_data [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [RANK_W-1:0] entry_rank [ENTRIES];
  logic [FILL_W-1:0] fill_count;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] oldest_oh;
  logic [ENTRIES-1:0] free_oh;
  logic [ENTRIES-1:0] slot_oh;
  logic               free_found;
  logic               hit_any;
  logic               is_put;
  logic               full;
  logic [RANK_W-1:0]  hit_rank;
  logic [DATA_W-1:0]  hit_data;
  logic [RANK_W-1:0]  oldest_rank;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   eff_cap;

  // Valid ranks are always 0 .. fill_count-1, so the oldest entry is the
  // one whose rank equals fill_count-1.
  assign oldest_rank = RANK_W'(fill_count - 1'b1);

  // Parallel key compare, oldest entry, and first free slot.
  always_comb begin
    hit_rank   = '0;
    hit_data   = '0;
    free_oh    = '0;
    free_found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = entry_valid[i] && (entry_key[i] == op.key);
      oldest_oh[i] = entry_valid[i] && (entry_rank[i] == oldest_rank);
      if (match[i]) begin
        hit_rank = hit_rank | entry_rank[i];
        hit_data = hit_data | entry_data[i];
      end
      if (!entry_valid[i] && !free_found) begin
        free_oh[i] = 1'b1;
        free_found = 1'b1;
      end
    end
  end

  // Effective capacity: zero counts as one, large values saturate.
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > ENTRIES_C) begin
      eff_cap = ENTRIES_C;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full    = CMP_W'(fill_count) >= eff_cap;
  assign hit_any = |match;
  assign is_put  = (op.func == FUNC_PUT);
  assign slot_oh = full ? oldest_oh : free_oh;

  // Lookup result; the caller uses it for gets only.
  assign res.hit        = hit_any;
  assign res.read_value = hit_any ? signed'(hit_data) : MISS_VALUE;

  // Valid bits, recency ranks and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fill_count  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_rank[i] <= '0;
      end
    end else if (en) begin
      if (hit_any) begin
        // Touch: entries newer than the hit entry age by one.
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            entry_rank[i] <= '0;
          end else if (entry_valid[i] && (entry_rank[i] < hit_rank)) begin
            entry_rank[i] <= entry_rank[i] + 1'b1;
          end
        end
      end else if (is_put) begin
        // Insert: every other valid entry ages, the new one is newest.
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_oh[i]) begin
            entry_valid[i] <= 1'b1;
            entry_rank[i]  <= '0;
          end else if (entry_valid[i]) begin
            entry_rank[i] <= entry_rank[i] + 1'b1;
          end
        end
        if (!full) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  // Key and data writes: update in place on a hit, fill the slot on a miss.
  always_ff @(posedge clk) begin
    if (en && is_put) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          entry_data[i] <= op.value;
        end else if (!hit_any && slot_oh[i]) begin
          entry_key[i]  <= op.key;
          entry_data[i] <= op.value;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // The number of valid entries always equals the fill count.
  a_fill_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(fill_count))
    else $error("fill count does not match the number of valid entries");

  // Keys are unique, so at most one entry matches.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("more than one entry matches the key");

  // An insert into a full cache evicts, so the fill count holds.
  a_evict_keeps_fill: assert property (@(posedge clk) disable iff (rst)
    (en && is_put && !hit_any && full) |=> $stable(fill_count))
    else $error("fill count changed on an evicting insert");

  // An insert always finds a slot.
  a_slot_found: assert property (@(posedge clk) disable iff (rst)
    (en && is_put && !hit_any) |-> $onehot(slot_oh))
    else $error("no unique slot for an insert");
`endif

endmodule
